// ----- design/euc_dense_byte_to_wide_decoder_defines.svh -----
// Assertion macros used by the port-level decoder checker.
`ifndef EUC_DENSE_BYTE_TO_WIDE_DECODER_DEFINES_SVH
`define EUC_DENSE_BYTE_TO_WIDE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EDBWD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edbwd check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EDBWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edbwd check failed");

`endif

// ----- design/edbwd_pkg.sv -----
// Types and constants of the EUC byte to wide character decoder.
package edbwd_pkg;

  // Accumulator shift per trail byte and cap on character length.
  localparam int          DIGIT_SHIFT    = 7;
  localparam logic [2:0]  MAX_CHAR_BYTES = 3'd4;

  // Byte classes.
  localparam logic [7:0] MIN_TRAIL = 8'ha0;
  localparam logic [7:0] C1_LOW    = 8'h80;
  localparam logic [7:0] C1_HIGH   = 8'h9f;
  localparam logic [7:0] SS2_BYTE  = 8'h8e;
  localparam logic [7:0] SS3_BYTE  = 8'h8f;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TRAIL = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  // Result queue depth: room for the two results of one byte plus one waiting.
  localparam int QUEUE_DEPTH = 3;

  typedef enum logic [1:0] {
    CS_NONE,
    CS_ONE,
    CS_TWO,
    CS_THREE
  } codeset_t;

  typedef enum logic [2:0] {
    REG_SINGLE_BYTE_MODE,
    REG_CS1_LENGTH,
    REG_CS2_LENGTH,
    REG_CS3_LENGTH,
    REG_CS1_BASE,
    REG_CS2_BASE,
    REG_CS3_BASE
  } reg_index_t;

  typedef struct packed {
    logic        single_byte_mode;
    logic [2:0]  codeset1_length;
    logic [2:0]  codeset2_length;
    logic [2:0]  codeset3_length;
    logic [31:0] codeset1_base;
    logic [31:0] codeset2_base;
    logic [31:0] codeset3_base;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [31:0] wide_char;
    logic [1:0]  status;
    logic [2:0]  bytes_used;
    logic        last;
  } out_item_t;

  // Results produced by one accepted byte, in order.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // Outcome of decoding a byte as the start of a character.
  typedef struct packed {
    logic       emit;
    out_item_t  item;
    logic       start;
    codeset_t   cs;
    logic [2:0] rem;
    logic [31:0] acc;
  } lead_t;

endpackage

// ----- design/edbwd_cfg.sv -----
// Configuration register file with its write decode.
module edbwd_cfg import edbwd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // Decode the register index of a write transfer; drop unknown indexes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SINGLE_BYTE_MODE: cfg_nxt.single_byte_mode = cfg_data[0];
        REG_CS1_LENGTH:       cfg_nxt.codeset1_length  = cfg_data[2:0];
        REG_CS2_LENGTH:       cfg_nxt.codeset2_length  = cfg_data[2:0];
        REG_CS3_LENGTH:       cfg_nxt.codeset3_length  = cfg_data[2:0];
        REG_CS1_BASE:         cfg_nxt.codeset1_base    = cfg_data;
        REG_CS2_BASE:         cfg_nxt.codeset2_base    = cfg_data;
        REG_CS3_BASE:         cfg_nxt.codeset3_base    = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.single_byte_mode <= 1'b0;
      cfg_r.codeset1_length  <= 3'd2;
      cfg_r.codeset2_length  <= 3'd1;
      cfg_r.codeset3_length  <= 3'd2;
      cfg_r.codeset1_base    <= 32'd0;
      cfg_r.codeset2_base    <= 32'd0;
      cfg_r.codeset3_base    <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- design/edbwd_core.sv -----
// Character decode state and per-byte decode logic.
module edbwd_core import edbwd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     in_fire,
  input  in_item_t in_item,
  output push_t    push
);

  logic        busy_r,  busy_nxt;
  logic [2:0]  rem_r,   rem_nxt;
  logic [2:0]  taken_r, taken_nxt;
  codeset_t    cs_r,    cs_nxt;
  logic [31:0] acc_r,   acc_nxt;

  lead_t       ld;
  logic [7:0]  off;
  logic [31:0] acc_sh;
  logic [2:0]  taken_inc;
  logic [2:0]  rem_dec;
  logic [31:0] base_sel;

  function automatic logic [2:0] clamp_len(input logic [2:0] n);
    return (n > MAX_CHAR_BYTES) ? MAX_CHAR_BYTES : n;
  endfunction

  // Decode one byte as the first byte of a character.
  function automatic lead_t lead_decode(input logic [7:0] b, input cfg_t c);
    lead_t      r;
    logic [2:0] len;
    logic [7:0] d;
    r   = '0;
    d   = b - MIN_TRAIL;
    len = 3'd0;
    r.item.status     = ST_OK;
    r.item.bytes_used = 3'd1;
    r.item.wide_char  = {24'd0, b};
    if (b < C1_LOW || c.single_byte_mode) begin
      r.emit = 1'b1;
    end else if (b == SS2_BYTE || b == SS3_BYTE) begin
      len = clamp_len((b == SS2_BYTE) ? c.codeset2_length : c.codeset3_length);
      if (len == 3'd0) begin
        r.emit = 1'b1;
      end else begin
        r.start = 1'b1;
        r.cs    = (b == SS2_BYTE) ? CS_TWO : CS_THREE;
        r.rem   = len;
        r.acc   = 32'd0;
      end
    end else if (b <= C1_HIGH) begin
      r.emit = 1'b1;
    end else begin
      len = clamp_len(c.codeset1_length);
      if (len <= 3'd1) begin
        r.emit           = 1'b1;
        r.item.wide_char = {24'd0, d} + c.codeset1_base;
      end else begin
        r.start = 1'b1;
        r.cs    = CS_ONE;
        r.rem   = len - 3'd1;
        r.acc   = {24'd0, d};
      end
    end
    return r;
  endfunction

  // Trail byte arithmetic.
  assign ld        = lead_decode(in_item.data_byte, cfg);
  assign off       = in_item.data_byte - MIN_TRAIL;
  assign acc_sh    = (acc_r << DIGIT_SHIFT) | {24'd0, off};
  assign taken_inc = taken_r + 3'd1;
  assign rem_dec   = rem_r - 3'd1;

  always_comb begin
    case (cs_r)
      CS_TWO:   base_sel = cfg.codeset2_base;
      CS_THREE: base_sel = cfg.codeset3_base;
      default:  base_sel = cfg.codeset1_base;
    endcase
  end

  // Advance the decode state and form the results of an accepted byte.
  always_comb begin
    busy_nxt  = busy_r;
    rem_nxt   = rem_r;
    taken_nxt = taken_r;
    cs_nxt    = cs_r;
    acc_nxt   = acc_r;
    push      = '0;
    if (in_fire) begin
      if (!busy_r) begin
        if (!in_item.end_of_stream) begin
          if (ld.emit) begin
            push.count = 2'd1;
            push.first = ld.item;
          end
          if (ld.start) begin
            busy_nxt  = 1'b1;
            rem_nxt   = ld.rem;
            taken_nxt = 3'd1;
            cs_nxt    = ld.cs;
            acc_nxt   = ld.acc;
          end
        end
      end else if (in_item.end_of_stream) begin
        // Stream ended inside a character.
        push.count            = 2'd1;
        push.first.wide_char  = 32'd0;
        push.first.status     = ST_TRUNCATED;
        push.first.bytes_used = taken_r;
        busy_nxt  = 1'b0;
        rem_nxt   = 3'd0;
        taken_nxt = 3'd0;
        cs_nxt    = CS_NONE;
      end else if (in_item.data_byte < MIN_TRAIL) begin
        // Bad trail byte: report it, then restart on the same byte.
        push.count            = 2'd1;
        push.first.wide_char  = 32'd0;
        push.first.status     = ST_BAD_TRAIL;
        push.first.bytes_used = taken_r;
        busy_nxt  = 1'b0;
        rem_nxt   = 3'd0;
        taken_nxt = 3'd0;
        cs_nxt    = CS_NONE;
        if (ld.emit) begin
          push.count  = 2'd2;
          push.second = ld.item;
        end
        if (ld.start) begin
          busy_nxt  = 1'b1;
          rem_nxt   = ld.rem;
          taken_nxt = 3'd1;
          cs_nxt    = ld.cs;
          acc_nxt   = ld.acc;
        end
      end else begin
        acc_nxt   = acc_sh;
        taken_nxt = taken_inc;
        rem_nxt   = rem_dec;
        if (rem_dec == 3'd0) begin
          push.count            = 2'd1;
          push.first.wide_char  = acc_sh + base_sel;
          push.first.status     = ST_OK;
          push.first.bytes_used = taken_inc;
          busy_nxt  = 1'b0;
          taken_nxt = 3'd0;
          cs_nxt    = CS_NONE;
        end
      end
      // Mark the final result of this byte.
      if (push.count == 2'd1) begin
        push.first.last = 1'b1;
      end else if (push.count == 2'd2) begin
        push.second.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      rem_r   <= 3'd0;
      taken_r <= 3'd0;
      cs_r    <= CS_NONE;
    end else begin
      busy_r  <= busy_nxt;
      rem_r   <= rem_nxt;
      taken_r <= taken_nxt;
      cs_r    <= cs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

// ----- design/edbwd_outq.sv -----
// Shifting result queue that takes up to two results per cycle while in_ready is high.
module edbwd_outq import edbwd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t  q_r   [QUEUE_DEPTH];
  out_item_t  q_nxt [QUEUE_DEPTH];
  out_item_t  q_sh  [QUEUE_DEPTH];
  logic [1:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] base;
  logic [1:0] base_p1;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = q_r[0];
  // Leave room for the two results one byte can cause.
  assign in_ready  = (count_r <= 2'd1);

  assign pop     = out_valid && out_ready;
  assign base    = count_r - {1'b0, pop};
  assign base_p1 = base + 2'd1;

  // Entries one place up, for the shift on a transfer out.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_sh[i] = (i == QUEUE_DEPTH - 1) ? q_r[i] : q_r[(i + 1) % QUEUE_DEPTH];
    end
  end

  // Shift on pop, append new results behind the kept ones.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (2'(i) < base) begin
        q_nxt[i] = pop ? q_sh[i] : q_r[i];
      end else if (push.count != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = push.first;
      end else if (push.count == 2'd2 && 2'(i) == base_p1) begin
        q_nxt[i] = push.second;
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    count_nxt = base + push.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

// ----- design/euc_dense_byte_to_wide_decoder.sv -----
// EUC byte stream to dense wide character decoder, top level.
//
// Input channel (in_valid/in_ready/in_data) carries one stream byte or an
// end-of-stream mark per transfer. Result channel (out_valid/out_ready/
// out_data) carries decoded characters and error reports; each byte gives
// zero, one or two results, and the last result of a byte has last set.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
// one register per transfer and is always ready; write it only while idle.
//
// Results are registered in the result queue before they reach out_data.
// Throughput: one byte per cycle while in_ready is high, set by the
// combinational decode feeding a three-entry result queue. A bad trail
// byte that also restarts a character gives two results; in_ready drops.
// When the receiver stalls the queue fills and in_ready falls once fewer
// than two entries are free; held results stay stable on out_data.
// Reset clears the decode state and the queue and loads the register
// defaults: multibyte mode, codeset lengths 2, 1 and 2, all bases zero.
module euc_dense_byte_to_wide_decoder import edbwd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t  cfg;
  push_t push;
  logic  in_fire;

  assign in_fire = in_valid && in_ready;

  edbwd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  edbwd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_fire (in_fire),
    .in_item (in_data),
    .push    (push)
  );

  edbwd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/edbwd_checker.sv -----
// Port-level checks of the decoder and their binding to the top level.
`include "euc_dense_byte_to_wide_decoder_defines.svh"

module edbwd_checker import edbwd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic in_xfer;
  logic ascii_byte;
  logic trunc_seen;

  assign in_xfer    = in_valid && in_ready;
  assign ascii_byte = !in_data.end_of_stream && (in_data.data_byte < C1_LOW);
  assign trunc_seen = out_valid && (out_data.status == ST_TRUNCATED);

  // Hold a stalled result.
  `EDBWD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // A plain ASCII byte always yields a result in the next cycle.
  `EDBWD_ASSERT_NEXT(a_ascii_result, in_xfer && ascii_byte, out_valid)

  // An empty result queue never stalls the input.
  `EDBWD_ASSERT_NOW(a_empty_ready, !out_valid, in_ready)

  // A truncation report carries no code and ends its byte's results.
  `EDBWD_ASSERT_NOW(a_trunc_form, trunc_seen, out_data.last && out_data.wide_char == 32'd0)

endmodule

bind euc_dense_byte_to_wide_decoder edbwd_checker u_edbwd_checker (.*);

// ----- test/euc_dense_byte_to_wide_decoder_checker.sv -----
// Checker for the EUC decoder: watches all three channels, predicts results and compares them.
module euc_dense_byte_to_wide_decoder_checker import edbwd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the register file and of the character in progress
  cfg_t        settings;
  logic        decoding;
  logic [2:0]  trail_left;
  logic [2:0]  bytes_seen;
  codeset_t    active_set;
  logic [31:0] code_acc;

  out_item_t   expected_results[$];
  int          mismatches = 0;

  function automatic out_item_t make_result(logic [31:0] wc, logic [1:0] st, logic [2:0] used);
    out_item_t r;
    r.wide_char  = wc;
    r.status     = st;
    r.bytes_used = used;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic [2:0] saturate_length(logic [2:0] n);
    return (n > MAX_CHAR_BYTES) ? MAX_CHAR_BYTES : n;
  endfunction

  function automatic logic [31:0] base_for(codeset_t cs);
    case (cs)
      CS_TWO:   return settings.codeset2_base;
      CS_THREE: return settings.codeset3_base;
      default:  return settings.codeset1_base;
    endcase
  endfunction

  function automatic void clear_decode();
    decoding   = 1'b0;
    trail_left = '0;
    bytes_seen = '0;
    active_set = CS_NONE;
    code_acc   = '0;
  endfunction

  // Decode b as the first byte of a character; return the number of results it gives
  function automatic int decode_lead(input logic [7:0] b, output out_item_t r);
    logic [2:0] len;
    r = '0;
    if (b < C1_LOW || settings.single_byte_mode) begin
      r = make_result({24'd0, b}, ST_OK, 3'd1);
      return 1;
    end
    if (b == SS2_BYTE || b == SS3_BYTE) begin
      len = saturate_length((b == SS2_BYTE) ? settings.codeset2_length
                                             : settings.codeset3_length);
      if (len == 3'd0) begin
        r = make_result({24'd0, b}, ST_OK, 3'd1);
        return 1;
      end
      decoding   = 1'b1;
      active_set = (b == SS2_BYTE) ? CS_TWO : CS_THREE;
      trail_left = len;
      bytes_seen = 3'd1;
      code_acc   = '0;
      return 0;
    end
    if (b <= C1_HIGH) begin
      r = make_result({24'd0, b}, ST_OK, 3'd1);
      return 1;
    end
    len = saturate_length(settings.codeset1_length);
    if (len <= 3'd1) begin
      r = make_result({24'd0, b - MIN_TRAIL} + settings.codeset1_base, ST_OK, 3'd1);
      return 1;
    end
    decoding   = 1'b1;
    active_set = CS_ONE;
    trail_left = len - 3'd1;
    bytes_seen = 3'd1;
    code_acc   = {24'd0, b - MIN_TRAIL};
    return 0;
  endfunction

  // Advance the shadow decoder by one input transfer and queue what it gives
  task automatic predict_transfer(input in_item_t it);
    out_item_t r [2];
    int        n;
    n    = 0;
    r[0] = '0;
    r[1] = '0;
    if (!decoding) begin
      if (!it.end_of_stream) n = decode_lead(it.data_byte, r[0]);
    end else if (it.end_of_stream) begin
      r[0] = make_result(32'd0, ST_TRUNCATED, bytes_seen);
      clear_decode();
      n = 1;
    end else if (it.data_byte < MIN_TRAIL) begin
      // Report the bad trail, then restart on the same byte
      r[0] = make_result(32'd0, ST_BAD_TRAIL, bytes_seen);
      clear_decode();
      n = 1 + decode_lead(it.data_byte, r[1]);
    end else begin
      code_acc   = (code_acc << DIGIT_SHIFT) | {24'd0, it.data_byte - MIN_TRAIL};
      bytes_seen = bytes_seen + 3'd1;
      trail_left = trail_left - 3'd1;
      if (trail_left == 3'd0) begin
        r[0] = make_result(code_acc + base_for(active_set), ST_OK, bytes_seen);
        clear_decode();
        n = 1;
      end
    end
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(r[i]);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      settings.single_byte_mode = 1'b0;
      settings.codeset1_length  = 3'd2;
      settings.codeset2_length  = 3'd1;
      settings.codeset3_length  = 3'd2;
      settings.codeset1_base    = '0;
      settings.codeset2_base    = '0;
      settings.codeset3_base    = '0;
      clear_decode();
      expected_results.delete();
    end else begin
      // Compare a result transfer with the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: wide_char=%h status=%0d bytes_used=%0d last=%0b",
                     out_data.wide_char, out_data.status, out_data.bytes_used, out_data.last);
        end else begin
          want = expected_results.pop_front();
          if (out_data.wide_char !== want.wide_char || out_data.status !== want.status ||
              out_data.bytes_used !== want.bytes_used || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected wide_char=%h status=%0d ",
                       want.wide_char, want.status,
                       "bytes_used=%0d last=%0b, ", want.bytes_used, want.last,
                       "got wide_char=%h status=%0d ", out_data.wide_char, out_data.status,
                       "bytes_used=%0d last=%0b", out_data.bytes_used, out_data.last);
          end
        end
      end
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SINGLE_BYTE_MODE: settings.single_byte_mode = cfg_data[0];
          REG_CS1_LENGTH:       settings.codeset1_length  = cfg_data[2:0];
          REG_CS2_LENGTH:       settings.codeset2_length  = cfg_data[2:0];
          REG_CS3_LENGTH:       settings.codeset3_length  = cfg_data[2:0];
          REG_CS1_BASE:         settings.codeset1_base    = cfg_data;
          REG_CS2_BASE:         settings.codeset2_base    = cfg_data;
          REG_CS3_BASE:         settings.codeset3_base    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_transfer(in_data);
    end
    fail_count  <= mismatches;
    outstanding <= expected_results.size();
  end

endmodule

// ----- test/euc_dense_byte_to_wide_decoder_tb.sv -----
// Testbench top for the EUC decoder: clock, reset, stimulus, idling and the verdict.
module euc_dense_byte_to_wide_decoder_tb;
  import edbwd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         RANDOM_ITEMS = 1900;
  localparam int         QUIET_TAIL   = 400;
  localparam int         CYCLE_LIMIT  = 600000;
  localparam logic [2:0] REG_UNUSED   = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count;
  int          outstanding;

  logic        idle_enable = 1'b1;
  int          items_sent  = 0;
  int          cycle_count = 0;
  int          stall_left  = 0;
  logic [2:0]  cur_len1 = 3'd2;
  logic [2:0]  cur_len2 = 3'd1;
  logic [2:0]  cur_len3 = 3'd2;

  euc_dense_byte_to_wide_decoder uut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  euc_dense_byte_to_wide_decoder_checker checker_i (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .outstanding
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result channel in random bursts
  initial out_ready = 1'b1;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one item, idling first now and then, and hold it until the transfer
  task automatic send_item(input in_item_t it);
    int gap;
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.data_byte     = b;
    it.end_of_stream = 1'b0;
    send_item(it);
  endtask

  // End of stream carries a junk byte that must be ignored
  task automatic send_end();
    in_item_t it;
    it.data_byte     = 8'($urandom_range(0, 255));
    it.end_of_stream = 1'b1;
    send_item(it);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Close the stream so the decoder is idle, then wait out every result
  task automatic drain_stream();
    send_end();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write every register; length and mode words carry random upper bits
  task automatic configure(input logic sbm, input logic [2:0] l1, input logic [2:0] l2,
                           input logic [2:0] l3, input logic [31:0] b1,
                           input logic [31:0] b2, input logic [31:0] b3);
    logic [31:0] word;
    cur_len1 = l1;
    cur_len2 = l2;
    cur_len3 = l3;
    write_register(REG_UNUSED, $urandom());
    word = $urandom(); word[0] = sbm;
    write_register(REG_SINGLE_BYTE_MODE, word);
    word = $urandom(); word[2:0] = l1;
    write_register(REG_CS1_LENGTH, word);
    word = $urandom(); word[2:0] = l2;
    write_register(REG_CS2_LENGTH, word);
    word = $urandom(); word[2:0] = l3;
    write_register(REG_CS3_LENGTH, word);
    write_register(REG_CS1_BASE, b1);
    write_register(REG_CS2_BASE, b2);
    write_register(REG_CS3_BASE, b3);
  endtask

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Trail bytes a well-formed character of the given codeset needs now
  function automatic int trail_count(input int which);
    logic [2:0] l;
    l = (which == 1) ? cur_len1 : (which == 2) ? cur_len2 : cur_len3;
    if (l > MAX_CHAR_BYTES) l = MAX_CHAR_BYTES;
    if (which == 1) return (l <= 3'd1) ? 0 : l - 1;
    return l;
  endfunction

  // Send one character: mostly well formed, some broken, truncated or noise
  task automatic send_character();
    int         pick;
    int         which;
    int         ntrail;
    int         bad_pos;
    int         cut_pos;
    logic [7:0] lead;
    pick = $urandom_range(0, 19);
    if (pick >= 18) begin
      if ($urandom_range(0, 3) == 0) send_end();
      else send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick >= 12 && pick <= 14) begin
      send_byte(8'($urandom_range(0, 8'h9f)));
      return;
    end
    which = (pick <= 5) ? 1 : (pick <= 8) ? 2 : (pick <= 11) ? 3 : $urandom_range(1, 3);
    lead  = (which == 1) ? 8'($urandom_range(8'ha0, 8'hff)) :
            (which == 2) ? SS2_BYTE : SS3_BYTE;
    ntrail  = trail_count(which);
    bad_pos = ((pick == 15 || pick == 16) && ntrail > 0) ? $urandom_range(0, ntrail - 1) : -1;
    cut_pos = (pick == 17) ? $urandom_range(0, ntrail) : -1;
    send_byte(lead);
    for (int i = 0; i < ntrail; i++) begin
      if (i == cut_pos) begin
        send_end();
        return;
      end
      if (i == bad_pos) send_byte(8'($urandom_range(0, 8'h9f)));
      else send_byte(8'($urandom_range(8'ha0, 8'hff)));
    end
    if (cut_pos == ntrail) send_end();
  endtask

  task automatic run_stream(input int count);
    int stop;
    stop = items_sent + count;
    while (items_sent < stop) send_character();
  endtask

  initial begin
    int start;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed bytes under the reset settings
    send_end();
    send_byte(8'h00); send_byte(8'h7f); send_byte(8'h80); send_byte(8'h9f);
    send_byte(8'ha0); send_byte(8'ha0);
    send_byte(8'hff); send_byte(8'hff);
    send_byte(SS2_BYTE); send_byte(8'hb1);
    send_byte(SS3_BYTE); send_byte(8'ha1); send_byte(8'hfe);
    // Bad trail restarting as ASCII, as SS3, as C1 and as SS2
    send_byte(8'hb0); send_byte(8'h41);
    send_byte(8'hb0); send_byte(SS3_BYTE); send_byte(8'ha5); send_end();
    send_byte(8'hc1); send_byte(8'h9f);
    send_byte(8'hd0); send_byte(SS2_BYTE); send_byte(8'ha0);
    drain_stream();

    // Extreme settings
    start = items_sent;
    configure(1'b1, 3'd4, 3'd4, 3'd4, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    run_stream(60);
    drain_stream();
    configure(1'b0, 3'd0, 3'd0, 3'd0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    run_stream(60);
    drain_stream();
    configure(1'b0, 3'd1, 3'd4, 3'd4, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    run_stream(80);
    drain_stream();
    configure(1'b0, 3'd7, 3'd7, 3'd7, $urandom(), $urandom(), $urandom());
    run_stream(80);
    drain_stream();
    configure(1'b0, 3'd4, 3'd1, 3'd1, 32'd0, 32'd0, 32'd0);
    run_stream(80);
    drain_stream();

    // Random settings; no idling near the end
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start >= RANDOM_ITEMS - QUIET_TAIL) idle_enable = 1'b0;
      else idle_enable = ($urandom_range(0, 3) != 0);
      configure($urandom_range(0, 7) == 0, 3'($urandom_range(0, 7)),
                3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                pick_base(), pick_base(), pick_base());
      run_stream($urandom_range(60, 200));
      drain_stream();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
